// ===== hdl/spe_pkg.sv =====
// Shared types, codes and constants of the SPI NOR erase/program sequencer.
package spe_pkg;

   localparam int PAGE_BYTES_DEF  = 256;
   localparam int CHUNK_BYTES_DEF = 29;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 25;
   localparam int OFFSET_W = 24;
   localparam int COUNT_W  = 9;   // a chunk never exceeds one 256-byte maximum
   localparam int CSR_IDX_W = 1;

   localparam logic [ADDR_W-1:0] WINDOW_BASE_RESET = 32'hBC00_0000;
   localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = 25'h020_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b1;

   localparam logic [7:0] OP_WREN = 8'h06;
   localparam logic [7:0] OP_RDSR = 8'h05;
   localparam logic [7:0] OP_SE   = 8'h20;
   localparam logic [7:0] OP_PP   = 8'h02;

   localparam logic [8:0] SE_SEND_BITS   = 9'd24;
   localparam logic [3:0] RDSR_RECV_BITS = 4'd8;

   typedef enum logic [1:0] {
      CMD_ERASE    = 2'd0,
      CMD_PROGRAM  = 2'd1,
      CMD_STATUS   = 2'd2,
      CMD_RESERVED = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      RC_DESCRIPTOR = 2'd0,
      RC_DONE       = 2'd1,
      RC_INVALID    = 2'd2,
      RC_BUSY       = 2'd3
   } result_code_type;

   // What the back end expands: a lone result, a status poll, or a triple.
   typedef enum logic [1:0] {
      JOB_SINGLE  = 2'd0,
      JOB_POLL    = 2'd1,
      JOB_ERASE   = 2'd2,
      JOB_PROGRAM = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type          kind;
      result_code_type       code;
      logic [OFFSET_W-1:0]   offset;
      logic [OFFSET_W-1:0]   source;
      logic [COUNT_W-1:0]    count;
   } job_type;

endpackage

// ===== hdl/spe_if.sv =====
// Channel interfaces: request, result and register write.
interface spe_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [spe_pkg::ADDR_W-1:0]    address;
   logic [spe_pkg::OFFSET_W-1:0]  length;
   logic [7:0]                    status_byte;
   modport source (output valid, command, address, length, status_byte, input ready);
   modport sink   (input valid, command, address, length, status_byte, output ready);
endinterface

interface spe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    result_code;
   logic [7:0]                    opcode;
   logic [8:0]                    send_bits;
   logic [3:0]                    recv_bits;
   logic [spe_pkg::OFFSET_W-1:0]  flash_offset;
   logic [spe_pkg::OFFSET_W-1:0]  source_offset;
   logic [4:0]                    data_count;
   logic                          last;
   modport source (output valid, result_code, opcode, send_bits, recv_bits, flash_offset,
                   source_offset, data_count, last, input ready);
   modport sink   (input valid, result_code, opcode, send_bits, recv_bits, flash_offset,
                   source_offset, data_count, last, output ready);
endinterface

interface spe_csr_if;
   logic                           valid;
   logic                           ready;
   logic [spe_pkg::CSR_IDX_W-1:0]  index;
   logic [spe_pkg::ADDR_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/spi_nor_program_erase_sequencer.sv =====
// Top level of the SPI NOR erase/program sequencer.
//
//  channel  | direction | carries
//  ---------+-----------+-----------------------------------------------------
//  req_ch   | in        | command, address, length, status_byte
//  rsp_ch   | out       | result_code, opcode, bit counts, offsets, count, last
//  csr_ch   | in        | index 0 window_base, index 1 window_size
//
// A request item is taken while the job queue has room.
// The back end sends one result item per cycle while the sink is ready and a job is queued:
// three items for a chunk or an erase (write enable, command, status read), one for a poll or a lone code.
// Reset is synchronous; it empties the queue and restores the window registers.
// A stalled result sink holds the output register; the queue then absorbs up
// to QUEUE_DEPTH jobs before req_ch.ready drops.
module spi_nor_program_erase_sequencer #(
   parameter int PAGE_BYTES  = spe_pkg::PAGE_BYTES_DEF,
   parameter int CHUNK_BYTES = spe_pkg::CHUNK_BYTES_DEF,
   parameter int QUEUE_DEPTH = spe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   spe_req_if.sink   req_ch,
   spe_rsp_if.source rsp_ch,
   spe_csr_if.sink   csr_ch
);
   import spe_pkg::*;

   logic    push;
   logic    full;
   logic    pop;
   logic    empty;
   job_type job_in;
   job_type job_out;

   spe_front #(
      .PAGE_BYTES  (PAGE_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .queue_full (full),
      .push       (push),
      .job        (job_in)
   );

   spe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (job_in),
      .full    (full),
      .pop     (pop),
      .empty   (empty),
      .job_out (job_out)
   );

   spe_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (empty),
      .job   (job_out),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

// ===== hdl/spe_front.sv =====
// Front end: window registers, request classification and chunk bookkeeping.
module spe_front #(
   parameter int PAGE_BYTES  = spe_pkg::PAGE_BYTES_DEF,
   parameter int CHUNK_BYTES = spe_pkg::CHUNK_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   spe_req_if.sink          req,
   spe_csr_if.sink          csr,
   input  logic             queue_full,
   output logic             push,
   output spe_pkg::job_type job
);
   import spe_pkg::*;

   localparam int PAGE_W = $clog2(PAGE_BYTES);

   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                waiting_ff, waiting_in;
   logic [OFFSET_W-1:0] next_offset_ff, next_offset_in;
   logic [OFFSET_W-1:0] bytes_left_ff, bytes_left_in;
   logic [OFFSET_W-1:0] source_ff, source_in;

   logic                accept;
   logic                starting;
   logic [ADDR_W-1:0]   diff;
   logic                in_window;
   logic [OFFSET_W-1:0] chunk_off;
   logic [OFFSET_W-1:0] chunk_left;
   logic [OFFSET_W-1:0] chunk_src;
   logic [PAGE_W-1:0]   page_pos;
   logic [PAGE_W:0]     page_room;
   logic [OFFSET_W-1:0] chunk;
   job_type             prog_job;

   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign diff      = req.address - base_ff;
   assign in_window = diff < {{(ADDR_W-SIZE_W){1'b0}}, size_ff};

   // First chunk comes from the request, later ones from the saved position.
   assign starting   = !waiting_ff;
   assign chunk_off  = starting ? diff[OFFSET_W-1:0] : next_offset_ff;
   assign chunk_left = starting ? req.length : bytes_left_ff;
   assign chunk_src  = starting ? '0 : source_ff;

   assign page_pos  = chunk_off[PAGE_W-1:0];
   assign page_room = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, page_pos};

   always_comb begin
      chunk = chunk_left;
      if (chunk > OFFSET_W'(CHUNK_BYTES)) begin
         chunk = OFFSET_W'(CHUNK_BYTES);
      end
      if (chunk > OFFSET_W'(page_room)) begin
         chunk = OFFSET_W'(page_room);
      end
   end

   always_comb begin
      prog_job        = '0;
      prog_job.kind   = JOB_PROGRAM;
      prog_job.code   = RC_DESCRIPTOR;
      prog_job.offset = chunk_off;
      prog_job.source = chunk_src;
      prog_job.count  = chunk[COUNT_W-1:0];
   end

   always_comb begin
      base_in        = base_ff;
      size_in        = size_ff;
      waiting_in     = waiting_ff;
      next_offset_in = next_offset_ff;
      bytes_left_in  = bytes_left_ff;
      source_in      = source_ff;
      push           = 1'b0;
      job            = '0;
      job.kind       = JOB_SINGLE;
      job.code       = RC_DONE;

      if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_WINDOW_BASE: base_in = csr.data;
            CSR_WINDOW_SIZE: size_in = csr.data[SIZE_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         case (command_type'(req.command))
            CMD_STATUS: begin
               if (waiting_ff) begin
                  push = 1'b1;
                  if (req.status_byte[0]) begin
                     job.kind = JOB_POLL;
                     job.code = RC_DESCRIPTOR;
                  end else if (bytes_left_ff != '0) begin
                     job            = prog_job;
                     next_offset_in = next_offset_ff + chunk;
                     source_in      = source_ff + chunk;
                     bytes_left_in  = bytes_left_ff - chunk;
                  end else begin
                     waiting_in = 1'b0;
                  end
               end
            end
            CMD_ERASE, CMD_PROGRAM: begin
               push = 1'b1;
               if (waiting_ff) begin
                  job.code = RC_BUSY;
               end else if (!in_window) begin
                  job.code = RC_INVALID;
               end else if (command_type'(req.command) == CMD_ERASE) begin
                  job.kind       = JOB_ERASE;
                  job.code       = RC_DESCRIPTOR;
                  job.offset     = diff[OFFSET_W-1:0];
                  next_offset_in = diff[OFFSET_W-1:0];
                  bytes_left_in  = '0;
                  source_in      = '0;
                  waiting_in     = 1'b1;
               end else if (req.length != '0) begin
                  job            = prog_job;
                  next_offset_in = diff[OFFSET_W-1:0] + chunk;
                  source_in      = chunk;
                  bytes_left_in  = req.length - chunk;
                  waiting_in     = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= WINDOW_BASE_RESET;
         size_ff        <= WINDOW_SIZE_RESET;
         waiting_ff     <= 1'b0;
         next_offset_ff <= '0;
         bytes_left_ff  <= '0;
         source_ff      <= '0;
      end else begin
         base_ff        <= base_in;
         size_ff        <= size_in;
         waiting_ff     <= waiting_in;
         next_offset_ff <= next_offset_in;
         bytes_left_ff  <= bytes_left_in;
         source_ff      <= source_in;
      end
   end

endmodule

// ===== hdl/spe_queue.sv =====
// Short job queue between the front and back ends.
module spe_queue #(
   parameter int DEPTH = spe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spe_pkg::job_type job_in,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output spe_pkg::job_type job_out
);
   import spe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign job_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ===== hdl/spe_back.sv =====
// Back end: expands queued jobs into result items behind an output register.
module spe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  spe_pkg::job_type job,
   output logic             pop,
   spe_rsp_if.source        rsp
);
   import spe_pkg::*;

   typedef enum logic [1:0] {
      STEP_WREN   = 2'd0,
      STEP_OP     = 2'd1,
      STEP_STATUS = 2'd2
   } step_type;

   step_type            step_ff, step_in;
   logic                valid_ff, valid_in;
   logic [1:0]          code_ff, code_in;
   logic [7:0]          opcode_ff, opcode_in;
   logic [8:0]          send_ff, send_in;
   logic [3:0]          recv_ff, recv_in;
   logic [OFFSET_W-1:0] foff_ff, foff_in;
   logic [OFFSET_W-1:0] soff_ff, soff_in;
   logic [4:0]          count_ff, count_in;
   logic                last_ff, last_in;

   logic                take;
   logic                triple;
   logic                last_step;
   logic [11:0]         pp_bytes;

   assign take      = (!valid_ff || rsp.ready) && !empty;
   assign triple    = (job.kind == JOB_ERASE) || (job.kind == JOB_PROGRAM);
   assign last_step = !triple || (step_ff == STEP_STATUS);
   assign pop       = take && last_step;
   assign pp_bytes  = 12'(job.count) + 12'd3;

   always_comb begin
      code_in   = RC_DESCRIPTOR;
      opcode_in = '0;
      send_in   = '0;
      recv_in   = '0;
      foff_in   = '0;
      soff_in   = '0;
      count_in  = '0;
      last_in   = last_step;
      case (job.kind)
         JOB_SINGLE: code_in = job.code;
         JOB_POLL: begin
            opcode_in = OP_RDSR;
            recv_in   = RDSR_RECV_BITS;
         end
         JOB_ERASE, JOB_PROGRAM: begin
            case (step_ff)
               STEP_WREN: opcode_in = OP_WREN;
               STEP_OP: begin
                  foff_in = job.offset;
                  if (job.kind == JOB_ERASE) begin
                     opcode_in = OP_SE;
                     send_in   = SE_SEND_BITS;
                  end else begin
                     opcode_in = OP_PP;
                     send_in   = 9'(pp_bytes << 3);
                     soff_in   = job.source;
                     count_in  = 5'(job.count);
                  end
               end
               default: begin
                  opcode_in = OP_RDSR;
                  recv_in   = RDSR_RECV_BITS;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (rsp.ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
         if (last_step) begin
            step_in = STEP_WREN;
         end else if (step_ff == STEP_WREN) begin
            step_in = STEP_OP;
         end else begin
            step_in = STEP_STATUS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_WREN;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
         // Hold the item until the sink takes it.
         if (take) begin
            code_ff   <= code_in;
            opcode_ff <= opcode_in;
            send_ff   <= send_in;
            recv_ff   <= recv_in;
            foff_ff   <= foff_in;
            soff_ff   <= soff_in;
            count_ff  <= count_in;
            last_ff   <= last_in;
         end
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.result_code   = code_ff;
   assign rsp.opcode        = opcode_ff;
   assign rsp.send_bits     = send_ff;
   assign rsp.recv_bits     = recv_ff;
   assign rsp.flash_offset  = foff_ff;
   assign rsp.source_offset = soff_ff;
   assign rsp.data_count    = count_ff;
   assign rsp.last          = last_ff;

endmodule

// ===== hdl/spe_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module spe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] result_code,
   input logic [7:0] opcode,
   input logic [8:0] send_bits,
   input logic [3:0] recv_bits,
   input logic       last
);
   import spe_pkg::*;

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_code_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_code != RC_DESCRIPTOR |-> last && opcode == '0 && send_bits == '0)
      else $error("status code item carries a descriptor or is not last");

   a_rdsr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_code == RC_DESCRIPTOR && opcode == OP_RDSR
      |-> last && recv_bits == RDSR_RECV_BITS)
      else $error("status read is not the closing item");

   a_wren_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_code == RC_DESCRIPTOR && opcode == OP_WREN |-> !last)
      else $error("write enable closes an item");

endmodule

bind spi_nor_program_erase_sequencer spe_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .result_code (rsp_ch.result_code),
   .opcode      (rsp_ch.opcode),
   .send_bits   (rsp_ch.send_bits),
   .recv_bits   (rsp_ch.recv_bits),
   .last        (rsp_ch.last)
);
